// ===== rtl/core/dimbt_pkg.sv =====
package dimbt_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned POS_W    = 48;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned ENTRY_W  = 32;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned FOFF_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned CFG_AW   = 4;

  // Parameter defaults for the top level.
  localparam int unsigned MAP_DEPTH_DEF  = 4096;
  localparam int unsigned MAX_CHUNKS_DEF = 64;

  // Register map, 8-byte stride; bit 3 of the address picks the register.
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_DATA_OFFSET = 1'b1;

  localparam logic [LEN_W-1:0] BLOCK_SIZE_RST  = 32'd1048576;
  localparam logic [POS_W-1:0] DATA_OFFSET_RST = '0;

  // Special map entries.
  localparam logic [ENTRY_W-1:0] ENTRY_UNALLOC = 32'hFFFF_FFFF;
  localparam logic [ENTRY_W-1:0] ENTRY_ZERO    = 32'hFFFF_FFFE;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNALLOC   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_BLK  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd4;

  // Input operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quotient;
    logic [LEN_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/core/dimbt_ram.sv =====
module dimbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/dimbt_div.sv =====
module dimbt_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dimbt_pkg::div_req_t req,
  output dimbt_pkg::div_rsp_t rsp
);
  import dimbt_pkg::*;

  localparam int unsigned CNT_W = $clog2(POS_W);

  logic [POS_W-1:0] q_r, q_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   diff;
  logic             fits;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
  assign shifted = {rem_r, q_r[POS_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[POS_W-2:0], fits};
      rem_nxt = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(POS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

  // A new division is only started while no other one is running.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("divider restarted while busy");

  // The remainder never reaches the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");

  // Completion follows the full run of steps.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

endmodule

// ===== rtl/core/dimbt_mul.sv =====
module dimbt_mul (
  input  logic                                clk,
  input  logic [dimbt_pkg::ENTRY_W-1:0]       a,
  input  logic [dimbt_pkg::LEN_W-1:0]         b,
  output logic [dimbt_pkg::FOFF_W-1:0]        p
);
  import dimbt_pkg::*;

  logic [FOFF_W-1:0] p_r;

  // Block number times block size, registered.
  always_ff @(posedge clk) begin
    p_r <= FOFF_W'(a) * FOFF_W'(b);
  end

  assign p = p_r;

endmodule

// ===== rtl/core/disk_image_block_map_translator_unit.sv =====
// Block map translator for a virtual disk image.
// Input channel (in_valid / in_stall): an item with op load writes one block
// map entry and is done in the cycle it is taken. An item with op read turns
// a byte range into image-file chunks, one result per block the range touches.
// Result channel (out_valid / out_stall): each result carries the file offset,
// chunk length, buffer offset, status and a last mark; errors end the run.
// Steps of a read: the item is taken, the bit-serial divider finds the first
// block and offset (one quotient bit per cycle), then each result passes
// through map read, multiply and output. A read whose clamped length is zero
// is done in the cycle it is taken and gives no result.
// The block takes no new item while a read is in progress; it does take one
// while its final result still waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits before producing the next one.
// Reset clears the control state and loads the register defaults; the block
// map itself is not cleared, and entries must be loaded before they are read.
// Configuration: block_size at address 0, data_offset at address 8.
module disk_image_block_map_translator_unit #(
  parameter int unsigned MAP_DEPTH  = dimbt_pkg::MAP_DEPTH_DEF,
  parameter int unsigned MAX_CHUNKS = dimbt_pkg::MAX_CHUNKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [dimbt_pkg::IDX_W-1:0]       in_map_index,
  input  logic [dimbt_pkg::ENTRY_W-1:0]     in_map_value,
  input  logic [dimbt_pkg::POS_W-1:0]       in_start_pos,
  input  logic [dimbt_pkg::LEN_W-1:0]       in_length,
  input  logic [dimbt_pkg::LEN_W-1:0]       in_buffer_length,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dimbt_pkg::FOFF_W-1:0]      out_file_offset,
  output logic [dimbt_pkg::LEN_W-1:0]       out_chunk_length,
  output logic [dimbt_pkg::LEN_W-1:0]       out_buffer_offset,
  output logic [dimbt_pkg::STATUS_W-1:0]    out_status,
  output logic                              out_last,
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dimbt_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [dimbt_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [dimbt_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                              cfg_pready
);
  import dimbt_pkg::*;

  localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_ENT  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  // Configuration registers
  logic [LEN_W-1:0] block_size_r;
  logic [POS_W-1:0] data_offset_r;
  logic             cfg_wr;

  // Sequencer state
  logic [2:0]          state_r, state_nxt;
  logic [LEN_W-1:0]    bs_r, bs_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [LEN_W-1:0]    done_r, done_nxt;
  logic [LEN_W-1:0]    span_r, span_nxt;
  logic [LEN_W-1:0]    chunk_r, chunk_nxt;
  logic [LEN_W-1:0]    off_r, off_nxt;
  logic [POS_W-1:0]    blk_r, blk_nxt;
  logic [POS_W:0]      base_r, base_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                final_r, final_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [FOFF_W-1:0]   out_foff_r, out_foff_nxt;
  logic [LEN_W-1:0]    out_clen_r, out_clen_nxt;
  logic [LEN_W-1:0]    out_boff_r, out_boff_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic              in_acc;
  logic              slot_free;
  logic [LEN_W-1:0]  len_clamp;
  logic [LEN_W-1:0]  bs_eff;
  logic              ram_we;
  logic [ENTRY_W-1:0] entry;
  logic [FOFF_W-1:0] product;
  logic              err_last;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Configuration port: zero-wait writes and reads.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= BLOCK_SIZE_RST;
      data_offset_r <= DATA_OFFSET_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[3] == REG_BLOCK_SIZE) begin
        block_size_r <= cfg_pwdata[LEN_W-1:0];
      end else begin
        data_offset_r <= cfg_pwdata[POS_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[3] == REG_BLOCK_SIZE) begin
      cfg_prdata = CFG_DW'(block_size_r);
    end else begin
      cfg_prdata = CFG_DW'(data_offset_r);
    end
  end

  // Handshakes.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign slot_free = ~out_valid_r | ~out_stall;

  assign len_clamp = (in_length > in_buffer_length) ? in_buffer_length : in_length;
  assign bs_eff    = (block_size_r == '0) ? LEN_W'(1) : block_size_r;

  // Block map storage; loads land only while idle.
  assign ram_we = in_acc & (in_op == OP_LOAD) &
                  (32'(in_map_index) < 32'(MAP_DEPTH));

  dimbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(in_map_index)),
    .wr_data (in_map_value),
    .rd_addr (AW'(blk_r)),
    .rd_data (entry)
  );

  // Single divider for position over block size, used once per read.
  assign div_req.start    = in_acc & (in_op == OP_READ) & (len_clamp != '0);
  assign div_req.dividend = in_start_pos;
  assign div_req.divisor  = bs_eff;

  dimbt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  dimbt_mul u_mul (
    .clk (clk),
    .a   (entry),
    .b   (bs_r),
    .p   (product)
  );

  assign err_last = (status_r != ST_OK);

  // Sequencer: divide once, then check, read, multiply and emit per chunk.
  always_comb begin
    state_nxt      = state_r;
    bs_nxt         = bs_r;
    rem_nxt        = rem_r;
    done_nxt       = done_r;
    span_nxt       = span_r;
    chunk_nxt      = chunk_r;
    off_nxt        = off_r;
    blk_nxt        = blk_r;
    base_nxt       = base_r;
    n_nxt          = n_r;
    status_nxt     = status_r;
    final_nxt      = final_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_foff_nxt   = out_foff_r;
    out_clen_nxt   = out_clen_r;
    out_boff_nxt   = out_boff_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (div_req.start) begin
          bs_nxt    = bs_eff;
          rem_nxt   = len_clamp;
          done_nxt  = '0;
          n_nxt     = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          blk_nxt   = div_rsp.quotient;
          off_nxt   = div_rsp.remainder;
          span_nxt  = bs_r - div_rsp.remainder;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // Chunk size, map range check; the map read is issued here.
        chunk_nxt  = (span_r > rem_r) ? rem_r : span_r;
        status_nxt = ST_OK;
        if (blk_r >= POS_W'(MAP_DEPTH)) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_ENT;
        end
      end
      S_ENT: begin
        // Entry is valid now; the product registers on this edge.
        final_nxt = (chunk_r == rem_r);
        base_nxt  = (POS_W + 1)'(off_r) + (POS_W + 1)'(data_offset_r);
        if ((n_r == CW'(MAX_CHUNKS - 1)) && (chunk_r != rem_r)) begin
          status_nxt = ST_TOO_MANY;
        end else if (entry == ENTRY_UNALLOC) begin
          status_nxt = ST_UNALLOC;
        end else if (entry == ENTRY_ZERO) begin
          status_nxt = ST_ZERO_BLK;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_boff_nxt   = done_r;
          out_status_nxt = status_r;
          if (err_last) begin
            out_foff_nxt = '0;
            out_clen_nxt = '0;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_foff_nxt = product + FOFF_W'(base_r);
            out_clen_nxt = chunk_r;
            out_last_nxt = final_r;
            if (final_r) begin
              state_nxt = S_IDLE;
            end else begin
              // Advance to the next block; later chunks start at offset zero.
              done_nxt  = done_r + chunk_r;
              rem_nxt   = rem_r - chunk_r;
              blk_nxt   = blk_r + 1'b1;
              off_nxt   = '0;
              span_nxt  = bs_r;
              n_nxt     = n_r + 1'b1;
              state_nxt = S_CHK;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      status_r    <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      status_r    <= status_nxt;
    end
    bs_r         <= bs_nxt;
    rem_r        <= rem_nxt;
    done_r       <= done_nxt;
    span_r       <= span_nxt;
    chunk_r      <= chunk_nxt;
    off_r        <= off_nxt;
    blk_r        <= blk_nxt;
    base_r       <= base_nxt;
    final_r      <= final_nxt;
    out_foff_r   <= out_foff_nxt;
    out_clen_r   <= out_clen_nxt;
    out_boff_r   <= out_boff_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_file_offset   = out_foff_r;
  assign out_chunk_length  = out_clen_r;
  assign out_buffer_offset = out_boff_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;

  // Every error result closes its run.
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> out_last)
    else $error("error result without last mark");

  // A good chunk always moves at least one byte.
  a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK)) |-> (out_chunk_length != '0))
    else $error("empty chunk reported as good");

  // The divider only finishes while the sequencer waits for it.
  a_div_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("division finished outside the divide step");

  // The chunk count stays below the run limit.
  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (32'(n_r) < 32'(MAX_CHUNKS)))
    else $error("chunk count beyond limit");

  // A chunk never runs past the remaining length.
  a_chunk_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENT) |-> (chunk_r <= rem_r))
    else $error("chunk longer than remaining length");

endmodule

// ===== bench/dimbt_chunk_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register ports of the translator, keeps its own
// copy of the block map and registers, and checks every result in order.
module dimbt_chunk_checker #(
  parameter int unsigned MAP_DEPTH  = dimbt_pkg::MAP_DEPTH_DEF,
  parameter int unsigned MAX_CHUNKS = dimbt_pkg::MAX_CHUNKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_op,
  input  logic [dimbt_pkg::IDX_W-1:0]    in_map_index,
  input  logic [dimbt_pkg::ENTRY_W-1:0]  in_map_value,
  input  logic [dimbt_pkg::POS_W-1:0]    in_start_pos,
  input  logic [dimbt_pkg::LEN_W-1:0]    in_length,
  input  logic [dimbt_pkg::LEN_W-1:0]    in_buffer_length,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [dimbt_pkg::FOFF_W-1:0]   out_file_offset,
  input  logic [dimbt_pkg::LEN_W-1:0]    out_chunk_length,
  input  logic [dimbt_pkg::LEN_W-1:0]    out_buffer_offset,
  input  logic [dimbt_pkg::STATUS_W-1:0] out_status,
  input  logic                           out_last,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dimbt_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dimbt_pkg::CFG_DW-1:0]   cfg_pwdata,
  input  logic [dimbt_pkg::CFG_DW-1:0]   cfg_prdata,
  input  logic                           cfg_pready,
  output int                             mismatches,
  output int                             pending,
  output int                             chunks_checked
);
  import dimbt_pkg::*;

  typedef struct packed {
    logic [FOFF_W-1:0]   foff;
    logic [LEN_W-1:0]    chunk_length;
    logic [LEN_W-1:0]    buffer_offset;
    logic [STATUS_W-1:0] status;
    logic                last;
  } chunk_t;

  chunk_t             chunks_due[$];
  logic [ENTRY_W-1:0] map_shadow [MAP_DEPTH];
  logic [LEN_W-1:0]   blk_size;
  logic [POS_W-1:0]   data_off;
  chunk_t             got_chunk;
  logic [CFG_DW-1:0]  reg_want;

  initial begin
    mismatches     = 0;
    pending        = 0;
    chunks_checked = 0;
  end

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Walk the blocks touched by a read and queue one chunk per block, stopping
  // at the first error.
  task automatic chunk_read(input logic [POS_W-1:0] spos, input logic [LEN_W-1:0] req_len,
                            input logic [LEN_W-1:0] buf_len);
    logic [63:0]        bse, blk, off, done, span, total;
    logic [ENTRY_W-1:0] entry;
    chunk_t             c;
    int                 n;
    bit                 fin, stop;
    total = (req_len > buf_len) ? {32'b0, buf_len} : {32'b0, req_len};
    bse   = (blk_size == '0) ? 64'd1 : {32'b0, blk_size};
    blk   = {16'b0, spos} / bse;
    off   = {16'b0, spos} % bse;
    done  = '0;
    span  = bse - off;
    if (span > total) span = total;
    n    = 0;
    stop = 1'b0;
    while (!stop && done < total) begin
      fin             = (done + span >= total);
      c               = '0;
      c.buffer_offset = done[LEN_W-1:0];
      c.last          = 1'b1;
      stop            = 1'b1;
      if (blk >= 64'(MAP_DEPTH)) begin
        c.status = ST_RANGE;
      end else if (n == int'(MAX_CHUNKS) - 1 && !fin) begin
        c.status = ST_TOO_MANY;
      end else begin
        entry = map_shadow[blk[IDX_W-1:0]];
        if (entry == ENTRY_UNALLOC) begin
          c.status = ST_UNALLOC;
        end else if (entry == ENTRY_ZERO) begin
          c.status = ST_ZERO_BLK;
        end else begin
          // The sum wraps at 64 bits.
          c.foff         = {32'b0, entry} * bse + off + {16'b0, data_off};
          c.chunk_length = span[LEN_W-1:0];
          c.status       = ST_OK;
          c.last         = fin;
          stop           = 1'b0;
        end
      end
      chunks_due.push_back(c);
      n++;
      done += span;
      off  = '0;
      blk++;
      span = bse;
      if (done + span > total) span = total - done;
    end
  endtask

  // Results are checked before new items are predicted in the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      blk_size = BLOCK_SIZE_RST;
      data_off = DATA_OFFSET_RST;
    end else begin
      if (out_valid && !out_stall) begin
        if (chunks_due.size() == 0) begin
          note_mismatch("unexpected result, file offset", out_file_offset, 64'd0);
        end else begin
          got_chunk = chunks_due.pop_front();
          if (out_file_offset !== got_chunk.foff)
            note_mismatch("file offset", out_file_offset, got_chunk.foff);
          if (out_chunk_length !== got_chunk.chunk_length)
            note_mismatch("chunk_length", 64'(out_chunk_length), 64'(got_chunk.chunk_length));
          if (out_buffer_offset !== got_chunk.buffer_offset)
            note_mismatch("buffer_offset", 64'(out_buffer_offset),
                          64'(got_chunk.buffer_offset));
          if (out_status !== got_chunk.status)
            note_mismatch("status", 64'(out_status), 64'(got_chunk.status));
          if (out_last !== got_chunk.last)
            note_mismatch("last", 64'(out_last), 64'(got_chunk.last));
          chunks_checked++;
        end
      end

      // Register writes update the shadow copy; reads are checked against it.
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[3] == REG_BLOCK_SIZE) blk_size = cfg_pwdata[LEN_W-1:0];
          else data_off = cfg_pwdata[POS_W-1:0];
        end else begin
          reg_want = (cfg_paddr[3] == REG_BLOCK_SIZE) ? {32'b0, blk_size} : {16'b0, data_off};
          if (cfg_prdata !== reg_want) note_mismatch("register readback", cfg_prdata, reg_want);
        end
      end

      if (in_valid && !in_stall) begin
        if (in_op == OP_LOAD) begin
          if (32'(in_map_index) < MAP_DEPTH) map_shadow[in_map_index] = in_map_value;
        end else begin
          chunk_read(in_start_pos, in_length, in_buffer_length);
        end
      end
    end
    pending = chunks_due.size();
  end

endmodule

// ===== bench/disk_image_block_map_translator_unit_tb.sv =====
`timescale 1ns / 1ps

module disk_image_block_map_translator_unit_tb;
  import dimbt_pkg::*;

  localparam int unsigned  HOLD_CYCLES = 400;
  localparam int unsigned  QUIET_LIMIT = 4000;
  localparam int unsigned  READ_SETTLE = 64;
  localparam logic [47:0]  MIB         = 48'h10_0000;
  localparam logic [47:0]  POS_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0]  LEN_MAX     = 32'hFFFF_FFFF;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_op;
  logic [IDX_W-1:0]    in_map_index;
  logic [ENTRY_W-1:0]  in_map_value;
  logic [POS_W-1:0]    in_start_pos;
  logic [LEN_W-1:0]    in_length;
  logic [LEN_W-1:0]    in_buffer_length;
  logic                out_valid;
  logic                out_stall;
  logic [FOFF_W-1:0]   out_file_offset;
  logic [LEN_W-1:0]    out_chunk_length;
  logic [LEN_W-1:0]    out_buffer_offset;
  logic [STATUS_W-1:0] out_status;
  logic                out_last;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;
  int                  mismatches;
  int                  pending;
  int                  chunks_checked;

  bit                  loaded [MAP_DEPTH_DEF];
  bit                  gaps_on;
  bit                  specials_on;
  bit                  hold_out;
  logic [LEN_W-1:0]    cur_bs;
  int unsigned         quiet;
  int                  n_loads, n_reads, n_settings;

  disk_image_block_map_translator_unit i_dut (.*);
  dimbt_chunk_checker i_chunk_checker (.*);

  // Clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: ends the run after a long stretch with no handshake at all.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", pending);
      $display("disk_image_block_map_translator_unit_tb failed");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 13);
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Map entry value; the unallocated and zero-block markers only when allowed.
  function automatic logic [31:0] pick_entry();
    logic [31:0] v;
    int unsigned r;
    v = $urandom;
    r = $urandom_range(99);
    if (specials_on && r < 6) v = ENTRY_UNALLOC;
    else if (specials_on && r < 12) v = ENTRY_ZERO;
    else if (v >= ENTRY_ZERO) v = v - 32'd2;
    return v;
  endfunction

  // Offer one item and wait until the block takes it.
  task automatic drive_item(input logic op, input logic [IDX_W-1:0] idx,
                            input logic [ENTRY_W-1:0] val, input logic [POS_W-1:0] spos,
                            input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] blen);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_map_index     <= idx;
    in_map_value     <= val;
    in_start_pos     <= spos;
    in_length        <= len;
    in_buffer_length <= blen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
    drive_item(OP_LOAD, idx, val, rand48(), $urandom, $urandom);
    loaded[idx] = 1'b1;
    n_loads++;
  endtask

  // Issue a read, first loading every map entry that it may look at.
  task automatic read_range(input logic [POS_W-1:0] spos, input logic [LEN_W-1:0] len,
                            input logic [LEN_W-1:0] blen);
    logic [63:0] bse, first, nblk, total, j;
    total = (len > blen) ? {32'b0, blen} : {32'b0, len};
    if (total != 0) begin
      bse   = (cur_bs == '0) ? 64'd1 : {32'b0, cur_bs};
      first = {16'b0, spos} / bse;
      nblk  = ({16'b0, spos} % bse + total + bse - 64'd1) / bse;
      if (nblk > 64'(MAX_CHUNKS_DEF)) nblk = 64'(MAX_CHUNKS_DEF) - 64'd1;
      for (j = 0; j < nblk; j++) begin
        if (first + j < 64'(MAP_DEPTH_DEF) && !loaded[first[IDX_W-1:0] + j[IDX_W-1:0]])
          load_entry(first[IDX_W-1:0] + j[IDX_W-1:0], pick_entry());
      end
    end
    drive_item(OP_READ, 12'($urandom_range(4095)), $urandom, spos, len, blen);
    n_reads++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Drained, plus time for a read that produces nothing to finish.
  task automatic settle();
    wait_drained();
    repeat (READ_SETTLE) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic sel, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {sel, 3'b000};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write both registers while idle and read each back.
  task automatic set_config(input logic [LEN_W-1:0] bs, input logic [POS_W-1:0] doff);
    settle();
    cfg_access(1'b1, REG_BLOCK_SIZE, {32'b0, bs});
    cfg_access(1'b0, REG_BLOCK_SIZE, '0);
    cfg_access(1'b1, REG_DATA_OFFSET, {16'b0, doff});
    cfg_access(1'b0, REG_DATA_OFFSET, '0);
    cur_bs = bs;
    n_settings++;
  endtask

  // Mostly well-formed reads near mapped blocks, with some stray loads and
  // reads from arbitrary positions.
  task automatic random_item();
    logic [63:0] bse, lim, blk, spos;
    logic [31:0] len, blen;
    int unsigned r;
    r   = $urandom_range(99);
    bse = (cur_bs == '0) ? 64'd1 : {32'b0, cur_bs};
    if (r < 15) begin
      load_entry(12'($urandom_range(4095)), pick_entry());
    end else if (r < 20) begin
      read_range(rand48(), $urandom, $urandom);
    end else begin
      blk = ($urandom_range(7) == 0) ? 64'($urandom_range(4095, 4088))
                                     : 64'($urandom_range(4095));
      spos = blk * bse + ({32'b0, $urandom} % bse);
      lim  = 64'd4 * bse;
      if (lim > 64'(LEN_MAX)) lim = 64'(LEN_MAX);
      case ($urandom_range(15))
        0:       len = '0;
        1:       len = $urandom;
        default: len = 32'(64'd1 + {32'b0, $urandom} % lim);
      endcase
      case ($urandom_range(7))
        0:       blen = $urandom;
        1:       blen = len >> 1;
        2:       blen = len;
        default: blen = LEN_MAX;
      endcase
      read_range(spos[47:0], len, blen);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_LOAD;
    in_map_index     = '0;
    in_map_value     = '0;
    in_start_pos     = '0;
    in_length        = '0;
    in_buffer_length = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    gaps_on          = 1'b1;
    specials_on      = 1'b0;
    hold_out         = 1'b0;
    cur_bs           = BLOCK_SIZE_RST;
    n_loads          = 0;
    n_reads          = 0;
    n_settings       = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers must read back their reset values.
    cfg_access(1'b0, REG_BLOCK_SIZE, '0);
    cfg_access(1'b0, REG_DATA_OFFSET, '0);

    // Reset settings: entry extremes, the special markers and length clamping.
    load_entry(12'd0, 32'h0);
    load_entry(12'd1, 32'hFFFF_FFFD);
    load_entry(12'd2, ENTRY_UNALLOC);
    load_entry(12'd3, ENTRY_ZERO);
    load_entry(12'd4095, $urandom);
    read_range(48'd0, 32'd0, LEN_MAX);
    read_range(48'd0, LEN_MAX, 32'd0);
    read_range(48'd0, 32'd100, 32'd50);
    read_range(MIB - 48'd1, 32'd2, LEN_MAX);
    read_range(2 * MIB + 48'd5, 32'd10, LEN_MAX);
    read_range(3 * MIB, 32'd1, LEN_MAX);
    read_range(MIB + 48'd7, 32'(3 * MIB), LEN_MAX);
    read_range(48'd4095 * MIB, 32'(2 * MIB), LEN_MAX);
    read_range(POS_MAX, LEN_MAX, LEN_MAX);

    // A block size of zero acts as one: a long read runs out of chunks, and
    // a short one walks off the end of the map.
    set_config(32'd0, POS_MAX);
    read_range(48'd1000, LEN_MAX, LEN_MAX);
    read_range(48'd4094, 32'd3, LEN_MAX);

    // Largest block size and data offset make the file offset wrap.
    set_config(LEN_MAX, POS_MAX);
    load_entry(12'd5, 32'hFFFF_FFFD);
    read_range(48'd6 * 48'(LEN_MAX) - 48'd1, LEN_MAX, LEN_MAX);

    // Random phases, each under its own register setting.
    specials_on = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_config(32'($urandom_range(64, 1)), 48'd0);
        1:       set_config(32'd4096, rand48());
        2:       set_config($urandom, rand48());
        3:       set_config(32'd512, 48'd0);
        4:       set_config(32'($urandom_range(8, 1)), rand48());
        default: set_config(32'h8000_0000, rand48());
      endcase
      gaps_on = (ph != 2);
      for (int k = 0; k < 11; k++) begin
        if (ph == 3 && k == 3) hold_out = 1'b1;
        if (ph == 4 && k == 5) wait_drained();
        random_item();
      end
    end

    gaps_on = 1'b1;
    settle();
    $display("Covered %0d map loads and %0d reads over %0d register settings,",
             n_loads, n_reads, n_settings);
    $display("with %0d chunk results checked and %0d mismatches.", chunks_checked, mismatches);
    if (mismatches == 0) begin
      $display("disk_image_block_map_translator_unit_tb passed");
    end else begin
      $display("disk_image_block_map_translator_unit_tb failed");
    end
    $finish;
  end

endmodule
